@@ design/lce_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lce_pkg: shared types and constants of the line code encoder
// Line levels, code and substitution selectors, and the command that the
// front part hands to the symbol sequencer through the command queue.
// ----------------------------------------------------------------------------
package lce_pkg;

    // half-bit line levels
    localparam logic [1:0] LV_LOW  = 2'd0;
    localparam logic [1:0] LV_ZERO = 2'd1;
    localparam logic [1:0] LV_HIGH = 2'd2;

    // line code selector values
    localparam logic [2:0] CODE_NRZL   = 3'd0;
    localparam logic [2:0] CODE_NRZI   = 3'd1;
    localparam logic [2:0] CODE_AMI    = 3'd2;
    localparam logic [2:0] CODE_PSEUDO = 3'd3;
    localparam logic [2:0] CODE_MANCH  = 3'd4;
    localparam logic [2:0] CODE_DMANCH = 3'd5;

    // zero substitution selector values
    localparam logic [1:0] SUB_NONE = 2'd0;
    localparam logic [1:0] SUB_B8ZS = 2'd1;
    localparam logic [1:0] SUB_HDB3 = 2'd2;

    // configuration register indexes
    localparam int         CFG_INDEX_W   = 1;
    localparam int         CFG_DATA_W    = 3;
    localparam logic [0:0] REG_LINE_CODE = 1'b0;
    localparam logic [0:0] REG_ZERO_SUB  = 1'b1;

    // zero run lengths for substitution
    localparam logic [3:0] RUN_B8ZS = 4'd8;
    localparam logic [3:0] RUN_HDB3 = 4'd4;

    // default command queue depth
    localparam int QUEUE_DEPTH = 4;

    // what follows the plain zeros of a command
    typedef enum logic [1:0] {
        OP_NONE,
        OP_BIT,
        OP_SUB8,
        OP_SUB4
    } op_t;

    // one command: some plain zeros, then one operation
    typedef struct packed {
        logic [2:0] zeros;
        op_t        op;
        logic       data_bit;
        logic [2:0] code;
        logic       eom;
    } cmd_t;

endpackage

@@ design/line_code_encoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_code_encoder_core: serial line code encoder
// Encodes one message bit per input transfer into half-bit symbol pairs.
// ----------------------------------------------------------------------------
// Usage: program line_code (index 0) and zero_substitution (index 1) through
// the write port while the block is idle. Each input transfer carries one
// data_bit and an end_of_message flag; each output transfer carries one bit
// period as first_half / second_half levels, with last_symbol set on the
// final symbol of a message. Both channels use valid and stall.
// Path: an input transfer that completes a command writes it into the command
// queue; the sequencer then loads the output register from the queue head.
// Throughput: one symbol per clock from the sequencer while the output is not
// stalled. A plain bit gives one symbol; in AMI with B8ZS or HDB3 a held zero
// gives none, and the bit that completes or breaks a run releases all symbols
// of its command (at most eight). The sequencer sets the pace; the input
// side keeps accepting while the command queue has room.
// Reset: clears the configuration to NRZ-L without substitution, drops held
// zeros, sets the line level high and the pulse parity even.
// Output stall holds the symbol; the queue then fills and input stall rises.
// ----------------------------------------------------------------------------
module line_code_encoder_core #(
    parameter int QUEUE_DEPTH = lce_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lce_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lce_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            data_bit,
    input  logic                            end_of_message,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      first_half,
    output logic [1:0]                      second_half,
    output logic                            last_symbol
);

    logic          push;
    lce_pkg::cmd_t push_cmd;
    logic          queue_full;
    logic          pop;
    logic          head_valid;
    lce_pkg::cmd_t head_cmd;

    // input classification
    lce_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_bit       (data_bit),
        .end_of_message (end_of_message),
        .queue_full     (queue_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // command queue
    lce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // symbol sequencer
    lce_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .first_half  (first_half),
        .second_half (second_half),
        .last_symbol (last_symbol)
    );

endmodule

@@ design/lce_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lce_front: input side of the line code encoder
// Holds the configuration registers and the count of held zeros, and turns
// input bits into commands for the symbol sequencer; a held zero gives none.
// ----------------------------------------------------------------------------
module lce_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lce_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lce_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            data_bit,
    input  logic                            end_of_message,
    input  logic                            queue_full,
    output logic                            push,
    output lce_pkg::cmd_t                   push_cmd
);

    logic [2:0] code_reg;
    logic [1:0] sub_reg;
    logic [2:0] fill_reg;
    logic [2:0] fill_next;
    logic [3:0] run_len;
    logic [3:0] fill_inc;
    logic [2:0] fill_after;
    logic       accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= lce_pkg::CODE_NRZL;
            sub_reg  <= lce_pkg::SUB_NONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lce_pkg::REG_LINE_CODE: code_reg <= cfg_data;
                lce_pkg::REG_ZERO_SUB:  sub_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;

    // substitution run length in force
    always_comb
    begin
        run_len = 4'd0;
        if (code_reg == lce_pkg::CODE_AMI)
        begin
            case (sub_reg)
                lce_pkg::SUB_B8ZS: run_len = lce_pkg::RUN_B8ZS;
                lce_pkg::SUB_HDB3: run_len = lce_pkg::RUN_HDB3;
                default:           run_len = 4'd0;
            endcase
        end
    end

    // classify the bit: flush and encode, substitute, or hold the zero
    always_comb
    begin
        fill_inc          = {1'b0, fill_reg} + 4'd1;
        fill_after        = 3'd0;
        push_cmd.zeros    = 3'd0;
        push_cmd.op       = lce_pkg::OP_NONE;
        push_cmd.data_bit = data_bit;
        push_cmd.code     = code_reg;
        push_cmd.eom      = end_of_message;
        if (run_len == 4'd0 || data_bit)
        begin
            push_cmd.zeros = fill_reg;
            push_cmd.op    = lce_pkg::OP_BIT;
        end
        else if (fill_inc >= run_len)
        begin
            push_cmd.zeros = 3'(fill_inc - run_len);
            push_cmd.op    = (run_len == lce_pkg::RUN_B8ZS) ? lce_pkg::OP_SUB8
                                                            : lce_pkg::OP_SUB4;
        end
        else
        begin
            fill_after = fill_inc[2:0];
        end
        // message end flushes any zeros still held
        if (end_of_message)
        begin
            if (push_cmd.op == lce_pkg::OP_NONE)
            begin
                push_cmd.zeros = fill_after;
            end
            fill_next = 3'd0;
        end
        else
        begin
            fill_next = fill_after;
        end
    end

    assign push = accept && (push_cmd.op != lce_pkg::OP_NONE || end_of_message);

    // held zero count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 3'd0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

endmodule

@@ design/lce_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lce_queue: command queue between front and sequencer
// Small circular buffer of commands; the head is presented to the reader.
// ----------------------------------------------------------------------------
module lce_queue #(
    parameter int DEPTH = lce_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lce_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output lce_pkg::cmd_t head_cmd
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    lce_pkg::cmd_t entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full       = (count_reg == CntW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // command storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ design/lce_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lce_back: symbol sequencer of the line code encoder
// Expands the head command into one symbol per cycle unless the output stalls,
// tracks line polarity and pulse parity, and drives the output register.
// ----------------------------------------------------------------------------
module lce_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  lce_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [1:0]    first_half,
    output logic [1:0]    second_half,
    output logic          last_symbol
);

    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       level_reg;
    logic       level_next;
    logic       odd_reg;
    logic       odd_next;
    logic       out_valid_reg;
    logic [1:0] first_reg;
    logic [1:0] second_reg;
    logic       last_reg;

    logic       load;
    logic       advance;
    logic [3:0] op_len;
    logic [3:0] total;
    logic       sym_last;
    logic [2:0] step;
    logic       in_zeros;
    logic       enc_bit;
    logic [1:0] sym_first;
    logic [1:0] sym_second;
    logic [1:0] pol_p;
    logic [1:0] pol_q;

    function automatic logic [1:0] pulse(input logic high);
        begin
            pulse = high ? lce_pkg::LV_HIGH : lce_pkg::LV_LOW;
        end
    endfunction

    assign load    = !out_valid_reg || !out_stall;
    assign advance = head_valid && load;

    // symbol count of the head command
    always_comb
    begin
        case (head_cmd.op)
            lce_pkg::OP_BIT:  op_len = 4'd1;
            lce_pkg::OP_SUB8: op_len = 4'd8;
            lce_pkg::OP_SUB4: op_len = 4'd4;
            default:          op_len = 4'd0;
        endcase
    end

    assign total    = {1'b0, head_cmd.zeros} + op_len;
    assign sym_last = ({1'b0, idx_reg} == total - 4'd1);
    assign in_zeros = (idx_reg < head_cmd.zeros);
    assign step     = idx_reg - head_cmd.zeros;
    assign enc_bit  = in_zeros ? 1'b0 : head_cmd.data_bit;
    assign pol_p    = pulse(level_reg);
    assign pol_q    = pulse(!level_reg);

    // current symbol and next polarity and parity
    always_comb
    begin
        sym_first  = lce_pkg::LV_ZERO;
        sym_second = lce_pkg::LV_ZERO;
        level_next = level_reg;
        odd_next   = odd_reg;
        if (in_zeros || head_cmd.op == lce_pkg::OP_BIT)
        begin
            case (head_cmd.code)
                lce_pkg::CODE_NRZI:
                begin
                    level_next = level_reg ^ enc_bit;
                    sym_first  = pulse(level_next);
                    sym_second = pulse(level_next);
                end
                lce_pkg::CODE_AMI:
                begin
                    if (enc_bit)
                    begin
                        level_next = !level_reg;
                        odd_next   = !odd_reg;
                        sym_first  = pol_q;
                        sym_second = pol_q;
                    end
                end
                lce_pkg::CODE_PSEUDO:
                begin
                    if (!enc_bit)
                    begin
                        level_next = !level_reg;
                        sym_first  = pol_q;
                        sym_second = pol_q;
                    end
                end
                lce_pkg::CODE_MANCH:
                begin
                    sym_first  = enc_bit ? lce_pkg::LV_LOW : lce_pkg::LV_HIGH;
                    sym_second = enc_bit ? lce_pkg::LV_HIGH : lce_pkg::LV_LOW;
                end
                lce_pkg::CODE_DMANCH:
                begin
                    // a zero adds a transition at the bit start
                    sym_first  = enc_bit ? pol_p : pol_q;
                    sym_second = enc_bit ? pol_q : pol_p;
                    level_next = enc_bit ? !level_reg : level_reg;
                end
                default:
                begin
                    sym_first  = enc_bit ? lce_pkg::LV_LOW : lce_pkg::LV_HIGH;
                    sym_second = sym_first;
                end
            endcase
        end
        else if (head_cmd.op == lce_pkg::OP_SUB8)
        begin
            // 0 0 0 P -P 0 -P P
            if (step inside {3'd3, 3'd7})
            begin
                sym_first = pol_p;
            end
            else if (step inside {3'd4, 3'd6})
            begin
                sym_first = pol_q;
            end
            sym_second = sym_first;
        end
        else if (head_cmd.op == lce_pkg::OP_SUB4)
        begin
            // odd parity: 0 0 0 P, even parity: -P 0 0 -P
            if (odd_reg)
            begin
                if (step == 3'd3)
                begin
                    sym_first = pol_p;
                end
            end
            else if (step == 3'd0 || step == 3'd3)
            begin
                sym_first = pol_q;
            end
            sym_second = sym_first;
            if (step == 3'd3)
            begin
                level_next = odd_reg ? level_reg : !level_reg;
                odd_next   = 1'b0;
            end
        end
        // message end returns line state to reset values
        if (sym_last && head_cmd.eom)
        begin
            level_next = 1'b1;
            odd_next   = 1'b0;
        end
    end

    assign idx_next = sym_last ? 3'd0 : idx_reg + 3'd1;
    assign pop      = advance && sym_last;

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            level_reg <= 1'b1;
            odd_reg   <= 1'b0;
        end
        else if (advance)
        begin
            idx_reg   <= idx_next;
            level_reg <= level_next;
            odd_reg   <= odd_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= head_valid;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            first_reg  <= sym_first;
            second_reg <= sym_second;
            last_reg   <= sym_last && head_cmd.eom;
        end
    end

    assign out_valid   = out_valid_reg;
    assign first_half  = first_reg;
    assign second_half = second_reg;
    assign last_symbol = last_reg;

    // a pending command never has its index past its last symbol
    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ({1'b0, idx_reg} < total))
        else $error("symbol index beyond command length");

    // index restarts after the last symbol of a command
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && sym_last) |=> (idx_reg == 3'd0))
        else $error("symbol index not cleared after command");

    // line state is back at reset values after a message end
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && sym_last && head_cmd.eom) |=> (level_reg && !odd_reg))
        else $error("line state not cleared at message end");

    // a message end symbol comes only with a loaded output
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && sym_last && head_cmd.eom) |=> (out_valid_reg && last_reg))
        else $error("message end symbol not presented");

endmodule
